// ===== hdl/chbc_pkg.sv =====
// ----------------------------------------------------------------------------
// chbc_pkg: shared definitions for the coverage hit counter
// Field widths, hash constants, pipeline sizing and the byte hash step.
// ----------------------------------------------------------------------------
package chbc_pkg;

  // beat field widths
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned SLOT_OUT_W = 16;
  localparam int unsigned COUNT_W    = 8;

  // default number of counter slots
  localparam int unsigned SLOT_COUNT_DEF = 65536;

  // hash: one pipeline stage per address byte
  localparam int unsigned HASH_BYTES = ADDR_W / 8;
  localparam logic [ADDR_W-1:0] HASH_OFFSET = 64'hcbf2_9ce4_8422_2325;

  // slot reduction: hash bits consumed per pipeline stage
  localparam int unsigned MOD_BITS   = 4;
  localparam int unsigned MOD_STAGES = ADDR_W / MOD_BITS;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // saturation value of a hit counter
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

  // one fnv-1a byte step: xor the byte in, then multiply by the prime
  // 2^40 + 435, built from shifts and adds (435 = 256 + 128 + 32 + 16 + 2 + 1)
  function automatic logic [ADDR_W-1:0] fnv_step(input logic [ADDR_W-1:0] acc,
                                                 input logic [7:0]        byte_in);
    logic [ADDR_W-1:0] x;
    x = acc ^ {{(ADDR_W-8){1'b0}}, byte_in};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== hdl/chbc_event_if.sv =====
// ----------------------------------------------------------------------------
// chbc_event_if: coverage event channel
// Valid/ready channel carrying one guard address and guard id per beat.
// ----------------------------------------------------------------------------
interface chbc_event_if;
  logic                        valid;
  logic                        ready;
  logic [chbc_pkg::ADDR_W-1:0] guard_address;
  logic [chbc_pkg::ID_W-1:0]   guard_id;

  modport source (output valid, output guard_address, output guard_id, input ready);
  modport sink   (input valid, input guard_address, input guard_id, output ready);
endinterface

// ===== hdl/chbc_result_if.sv =====
// ----------------------------------------------------------------------------
// chbc_result_if: hit counter result channel
// Valid/ready channel carrying slot, counter value and counted flag per beat.
// ----------------------------------------------------------------------------
interface chbc_result_if;
  logic                            valid;
  logic                            ready;
  logic [chbc_pkg::SLOT_OUT_W-1:0] slot_index;
  logic [chbc_pkg::COUNT_W-1:0]    hit_count;
  logic                            counted;

  modport source (output valid, output slot_index, output hit_count, output counted,
                  input ready);
  modport sink   (input valid, input slot_index, input hit_count, input counted,
                  output ready);
endinterface

// ===== hdl/chbc_front.sv =====
// ----------------------------------------------------------------------------
// chbc_front: hash and slot reduction pipeline
// Takes event beats, hashes the address one byte per stage, then reduces the
// hash modulo the slot count a few bits per stage. Stalls as a whole.
// ----------------------------------------------------------------------------
module chbc_front #(
  parameter int unsigned SLOT_COUNT = chbc_pkg::SLOT_COUNT_DEF,
  localparam int unsigned SLOT_W    = $clog2(SLOT_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  chbc_event_if.sink        evt_i,
  input  logic              hold_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic              out_nz_o
);

  localparam int unsigned HS = chbc_pkg::HASH_BYTES;
  localparam int unsigned MS = chbc_pkg::MOD_STAGES;
  localparam int unsigned MB = chbc_pkg::MOD_BITS;
  localparam int unsigned AW = chbc_pkg::ADDR_W;
  localparam int unsigned NS = HS + MS;
  localparam logic [SLOT_W:0] NMOD = (SLOT_W+1)'(SLOT_COUNT);

  // restoring remainder step over a few hash bits, msb first
  function automatic logic [SLOT_W-1:0] mod_step(input logic [SLOT_W-1:0] r,
                                                 input logic [MB-1:0]     bits);
    logic [SLOT_W:0]   t;
    logic [SLOT_W-1:0] acc;
    acc = r;
    for (int b = MB - 1; b >= 0; b--) begin
      t = {acc, bits[b]};
      if (t >= NMOD) t = t - NMOD;
      acc = t[SLOT_W-1:0];
    end
    return acc;
  endfunction

  logic          adv;
  logic          in_fire;
  logic [NS-1:0] v_q;

  logic [AW-1:0]     hacc_q  [HS];
  logic [AW-1:0]     haddr_q [HS];
  logic              hnz_q   [HS];
  logic [SLOT_W-1:0] mrem_q  [MS];
  logic [AW-1:0]     mhash_q [MS];
  logic              mnz_q   [MS];

  // whole pipeline moves when its last stage is empty or drained
  assign adv         = !v_q[NS-1] || out_ready_i;
  assign evt_i.ready = adv && !hold_i;
  assign in_fire     = evt_i.valid && evt_i.ready;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], in_fire};
    end
  end

  // hash stages, one address byte each
  for (genvar k = 0; k < HS; k++) begin : g_hash
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hacc_q[0]  <= chbc_pkg::fnv_step(chbc_pkg::HASH_OFFSET, evt_i.guard_address[7:0]);
          haddr_q[0] <= evt_i.guard_address;
          hnz_q[0]   <= (evt_i.guard_id != '0);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hacc_q[k]  <= chbc_pkg::fnv_step(hacc_q[k-1], haddr_q[k-1][8*k +: 8]);
          haddr_q[k] <= haddr_q[k-1];
          hnz_q[k]   <= hnz_q[k-1];
        end
      end
    end
  end

  // modulo stages, a nibble of the hash each
  for (genvar j = 0; j < MS; j++) begin : g_mod
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (adv) begin
          mrem_q[0]  <= mod_step('0, hacc_q[HS-1][AW-1 -: MB]);
          mhash_q[0] <= hacc_q[HS-1];
          mnz_q[0]   <= hnz_q[HS-1];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (adv) begin
          mrem_q[j]  <= mod_step(mrem_q[j-1], mhash_q[j-1][AW-1-MB*j -: MB]);
          mhash_q[j] <= mhash_q[j-1];
          mnz_q[j]   <= mnz_q[j-1];
        end
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_slot_o  = mrem_q[MS-1];
  assign out_nz_o    = mnz_q[MS-1];

endmodule

// ===== hdl/chbc_queue.sv =====
// ----------------------------------------------------------------------------
// chbc_queue: short fifo between front and back
// Registered storage, ready is not full, data is shown from the head entry.
// ----------------------------------------------------------------------------
module chbc_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = chbc_pkg::QUEUE_DEPTH,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
      if (push && !pop)      cnt_q <= cnt_q + CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CW'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== hdl/chbc_back.sv =====
// ----------------------------------------------------------------------------
// chbc_back: counter store read-modify-write
// Clears the counter memory after reset, then reads each slot counter, adds
// one with saturation if nz is set, writes it back and registers the result.
// ----------------------------------------------------------------------------
module chbc_back #(
  parameter int unsigned SLOT_COUNT = chbc_pkg::SLOT_COUNT_DEF,
  localparam int unsigned SLOT_W    = $clog2(SLOT_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  logic [SLOT_W-1:0] q_slot_i,
  input  logic              q_nz_i,
  output logic              clearing_o,
  chbc_result_if.source     res_o
);

  localparam int unsigned CNT_W = chbc_pkg::COUNT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  logic [CNT_W-1:0] mem [SLOT_COUNT];

  logic              clr_q;
  logic [SLOT_W-1:0] clr_addr_q;

  logic              m_valid_q;
  logic [SLOT_W-1:0] m_slot_q;
  logic              m_nz_q;
  logic [CNT_W-1:0]  rd_q;

  logic              fwd_valid_q;
  logic [SLOT_W-1:0] fwd_slot_q;
  logic [CNT_W-1:0]  fwd_val_q;

  logic                            out_valid_q;
  logic [chbc_pkg::SLOT_OUT_W-1:0] out_slot_q;
  logic [CNT_W-1:0]                out_count_q;
  logic                            out_counted_q;

  logic             m_fire, m_free, r_fire, inc;
  logic [CNT_W-1:0] cur, nxt;

  // read issues when the modify stage is free, modify retires into the output
  assign m_fire    = m_valid_q && (!out_valid_q || res_o.ready);
  assign m_free    = !m_valid_q || m_fire;
  assign q_ready_o = m_free && !clr_q;
  assign r_fire    = q_valid_i && q_ready_o;

  // last write is the newest value of its slot, covers the read racing it
  assign cur = (fwd_valid_q && (fwd_slot_q == m_slot_q)) ? fwd_val_q : rd_q;
  assign inc = m_nz_q && (cur != chbc_pkg::COUNT_MAX);
  assign nxt = cur + CNT_W'(inc);

  // counter memory: clearing pass, write back, registered read
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (m_fire && inc) begin
      mem[m_slot_q] <= nxt;
    end
    if (r_fire) rd_q <= mem[q_slot_i];
  end

  // clearing pass control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + SLOT_W'(1);
      if (clr_addr_q == LAST_SLOT) clr_q <= 1'b0;
    end
  end

  // stage and output valid, forward valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (r_fire)      m_valid_q <= 1'b1;
      else if (m_fire) m_valid_q <= 1'b0;
      if (m_fire)           out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
      if (m_fire && inc) fwd_valid_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (r_fire) begin
      m_slot_q <= q_slot_i;
      m_nz_q   <= q_nz_i;
    end
    if (m_fire) begin
      out_slot_q    <= chbc_pkg::SLOT_OUT_W'(m_slot_q);
      out_count_q   <= nxt;
      out_counted_q <= inc;
    end
    if (m_fire && inc) begin
      fwd_slot_q <= m_slot_q;
      fwd_val_q  <= nxt;
    end
  end

  assign clearing_o       = clr_q;
  assign res_o.valid      = out_valid_q;
  assign res_o.slot_index = out_slot_q;
  assign res_o.hit_count  = out_count_q;
  assign res_o.counted    = out_counted_q;

endmodule

// ===== hdl/coverage_hit_bitmap_counter_core.sv =====
// ----------------------------------------------------------------------------
// coverage_hit_bitmap_counter_core: coverage event hit counter
// Hashes event addresses into slots of saturating 8-bit counters.
// ----------------------------------------------------------------------------
// usage
//   evt_i : one coverage event per beat (guard_address, guard_id)
//   res_o : one result per event (slot_index, hit_count, counted)
//   a zero guard_id reports the slot and its count without changing it
// throughput: one event per cycle while res_o.ready holds, sustained by every stage
// path: 8 hash stages (one address byte each), 16 modulo stages (four hash
//   bits each), queue, memory read into the modify stage, and output
//   register
// reset: the counter memory is swept to zero, one slot per cycle, over all
//   SLOT_COUNT slots (65536 by default); evt_i.ready stays low meanwhile
// stall: a held result keeps its output register; the modify stage, queue
//   and hash pipeline fill behind it and then evt_i.ready drops
// a counter that reaches 255 stays there and reports counted low
// ----------------------------------------------------------------------------
module coverage_hit_bitmap_counter_core #(
  parameter int unsigned SLOT_COUNT = chbc_pkg::SLOT_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  chbc_event_if.sink    evt_i,
  chbc_result_if.source res_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);

  logic              f_valid, f_ready, f_nz;
  logic [SLOT_W-1:0] f_slot;
  logic              q_valid, q_ready;
  logic [SLOT_W:0]   q_data;
  logic              clearing;

  // hash and slot reduction
  chbc_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_i),
    .hold_i      (clearing),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_slot_o  (f_slot),
    .out_nz_o    (f_nz)
  );

  // decoupling queue
  chbc_queue #(.W(SLOT_W + 1), .DEPTH(chbc_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_nz, f_slot}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // counter store update
  chbc_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_slot_i   (q_data[SLOT_W-1:0]),
    .q_nz_i     (q_data[SLOT_W]),
    .clearing_o (clearing),
    .res_o      (res_o)
  );

endmodule
